FILE: design/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
`timescale 1ns / 1ps

package deq_pkg;

    // Request command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Where the word coming back from the slot memory goes
    typedef enum logic [1:0] {
        TGT_FRONT = 2'd0,
        TGT_BACK  = 2'd1,
        TGT_DATA  = 2'd2
    } t_target;

    localparam int unsigned IO_WORD_W  = 32;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned POSITION_W = 4;

endpackage

FILE: design/deq_ram.sv
// Slot memory of the queue: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WORD_WIDTH-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_WIDTH-1:0]    o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/double_ended_queue_unit.sv
// Top level of the double-ended queue: ring of slots, front pointer, count, result register.
`timescale 1ns / 1ps

//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  request  | i_in_valid / o_in_ready   | i_cmd, i_value, i_position
//  result   | o_out_valid / i_out_ready | o_data, o_status, o_count, o_is_empty,
//           |                           | o_front_word, o_back_word
//
//  Pushes, failed requests and unknown commands load the result register on
//  acceptance; a pop that leaves words behind and an in-range read pass first
//  through S_READ, as the slot memory read data is registered (the replacement
//  front/back word or the read word). One request is in flight at a time; a new
//  one is taken while the result register drains.
//  Reset (synchronous, active low) empties the queue and the result register;
//  slot contents are left as they are and are never read before being written.
//  A stalled result holds in the result register and blocks the next request.

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_cmd,
    input  logic signed [IO_WORD_W-1:0]  i_value,
    input  logic [POSITION_W-1:0]        i_position,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [IO_WORD_W-1:0]  o_data,
    output logic [1:0]                   o_status,
    output logic [COUNT_W-1:0]           o_count,
    output logic                         o_is_empty,
    output logic signed [IO_WORD_W-1:0]  o_front_word,
    output logic signed [IO_WORD_W-1:0]  o_back_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    // Ring index arithmetic: a + b modulo DEPTH, with b below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW + 1)'(a) + (CW + 1)'(b);
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return AW'(s);
    endfunction

    // Stored word to the 32-bit result field
    function automatic logic [IO_WORD_W-1:0] to_io(input logic [WORD_WIDTH-1:0] w);
        return IO_WORD_W'(w);
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                r_state,      n_state;
    t_target               r_target,     n_target;
    logic [AW-1:0]         r_front,      n_front;
    logic [CW-1:0]         r_count,      n_count;
    // Cached end words; meaningful only while the queue is not empty
    logic [WORD_WIDTH-1:0] r_front_word, n_front_word;
    logic [WORD_WIDTH-1:0] r_back_word,  n_back_word;
    logic [IO_WORD_W-1:0]  r_pend_data,  n_pend_data;

    // Result register
    logic                  r_out_valid;
    logic [IO_WORD_W-1:0]  r_out_data;
    t_status               r_out_status;
    logic [CW-1:0]         r_out_count;
    logic [IO_WORD_W-1:0]  r_out_front;
    logic [IO_WORD_W-1:0]  r_out_back;

    // Slot memory port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  load_out;
    logic                  is_full;
    logic                  is_empty_now;
    logic [WORD_WIDTH-1:0] push_word;
    logic [IO_WORD_W-1:0]  res_data;
    t_status               res_status;

    // Sign-extend or truncate the pushed word to the slot width
    assign push_word    = WORD_WIDTH'(i_value);
    assign is_full      = (r_count == DEPTH_C);
    assign is_empty_now = (r_count == '0);

    // Take a request only when nothing is in flight and the result register
    // will be free at the same edge
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    deq_ram #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (push_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state and memory access. Pushes only write and pops/reads only
    // read, so a read never meets a write to the same slot in one cycle.
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_target     = r_target;
        n_front      = r_front;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_pend_data  = r_pend_data;
        ram_we       = 1'b0;
        ram_waddr    = r_front;
        ram_re       = 1'b0;
        ram_raddr    = r_front;
        load_out     = 1'b0;
        res_data     = '0;
        res_status   = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load_out = 1'b1;
                    unique case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status = ST_FULL;
                            end else begin
                                n_front      = (r_front == '0) ? LAST_PTR : r_front - 1'b1;
                                ram_we       = 1'b1;
                                ram_waddr    = n_front;
                                n_front_word = push_word;
                                if (is_empty_now) begin
                                    n_back_word = push_word;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (is_full) begin
                                res_status = ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = wrap_add(r_front, r_count);
                                n_back_word = push_word;
                                if (is_empty_now) begin
                                    n_front_word = push_word;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty_now) begin
                                res_status = ST_EMPTY;
                                res_data   = '1;
                            end else begin
                                res_data = to_io(r_front_word);
                                n_front  = wrap_add(r_front, CW'(1));
                                n_count  = r_count - 1'b1;
                                if (r_count != CW'(1)) begin
                                    // fetch the word that becomes the new front
                                    ram_re      = 1'b1;
                                    ram_raddr   = n_front;
                                    n_target    = TGT_FRONT;
                                    n_pend_data = to_io(r_front_word);
                                    n_state     = S_READ;
                                    load_out    = 1'b0;
                                end
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty_now) begin
                                res_status = ST_EMPTY;
                                res_data   = '1;
                            end else begin
                                res_data = to_io(r_back_word);
                                n_count  = r_count - 1'b1;
                                if (r_count != CW'(1)) begin
                                    // fetch the word that becomes the new back
                                    ram_re      = 1'b1;
                                    ram_raddr   = wrap_add(r_front, r_count - CW'(2));
                                    n_target    = TGT_BACK;
                                    n_pend_data = to_io(r_back_word);
                                    n_state     = S_READ;
                                    load_out    = 1'b0;
                                end
                            end
                        end
                        CMD_READ: begin
                            if ((CW + POSITION_W)'(i_position) >= (CW + POSITION_W)'(r_count)) begin
                                res_status = ST_RANGE;
                                res_data   = '1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_add(r_front, CW'(i_position));
                                n_target  = TGT_DATA;
                                n_state   = S_READ;
                                load_out  = 1'b0;
                            end
                        end
                        default: begin
                            // unknown command: no operation
                        end
                    endcase
                end
            end
            S_READ: begin
                load_out = 1'b1;
                n_state  = S_IDLE;
                unique case (r_target)
                    TGT_FRONT: begin
                        n_front_word = ram_rdata;
                        res_data     = r_pend_data;
                    end
                    TGT_BACK: begin
                        n_back_word = ram_rdata;
                        res_data    = r_pend_data;
                    end
                    TGT_DATA: begin
                        res_data = to_io(ram_rdata);
                    end
                    default: begin
                        res_data = r_pend_data;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
        r_pend_data  <= n_pend_data;
        if (load_out) begin
            r_out_data   <= res_data;
            r_out_status <= res_status;
            r_out_count  <= n_count;
            // end words read as zero once the queue is empty
            r_out_front  <= (n_count == '0) ? '0 : to_io(n_front_word);
            r_out_back   <= (n_count == '0) ? '0 : to_io(n_back_word);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_out_data;
    assign o_status     = r_out_status;
    assign o_count      = COUNT_W'(r_out_count);
    assign o_is_empty   = (r_out_count == '0);
    assign o_front_word = r_out_front;
    assign o_back_word  = r_out_back;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("occupancy above DEPTH");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register busy while a memory read completes");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_PUSH_FRONT || i_cmd == CMD_PUSH_BACK) && !is_full)
        |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE) && o_out_valid)
        else $error("memory read did not produce a result");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_front_word == '0) && (o_back_word == '0))
        else $error("end words not cleared on empty queue");

endmodule

FILE: dv/tb_double_ended_queue_unit.sv
// Self-checking testbench for the double-ended queue unit against its own deque predictor.
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
    import deq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_HOLD_LEN   = 300;

    // Command encodings the block does not define; they must act as a no-op.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic signed [IO_WORD_W-1:0] data;
        t_status                     status;
        logic [COUNT_W-1:0]          count;
        logic                        is_empty;
        logic signed [IO_WORD_W-1:0] front_word;
        logic signed [IO_WORD_W-1:0] back_word;
    } t_result;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic [2:0]                   i_cmd       = '0;
    logic signed [IO_WORD_W-1:0]  i_value     = '0;
    logic [POSITION_W-1:0]        i_position  = '0;
    logic                         i_out_ready = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic signed [IO_WORD_W-1:0]  o_data;
    logic [1:0]                   o_status;
    logic [COUNT_W-1:0]           o_count;
    logic                         o_is_empty;
    logic signed [IO_WORD_W-1:0]  o_front_word;
    logic signed [IO_WORD_W-1:0]  o_back_word;

    // Predictor state: ring of words, front index and fill level
    logic signed [IO_WORD_W-1:0]  ring_words [DEPTH];
    logic [POSITION_W-1:0]        ring_front = '0;
    logic [COUNT_W-1:0]           ring_fill  = '0;

    t_result expected_results [$];

    int tx_idle_pct  = 25;
    int rx_idle_pct  = 25;
    logic rx_holding = 1'b0;
    event rx_hold_go;

    int err_count    = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_full_push  = 0;
    int n_empty_pop  = 0;
    int n_range_read = 0;
    int n_good_read  = 0;
    int n_good_pop   = 0;
    int cycle_count  = 0;

    double_ended_queue_unit #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (IO_WORD_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty),
        .o_front_word (o_front_word),
        .o_back_word  (o_back_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the predictor and return the result it must produce.
    function automatic t_result deque_apply(input logic [2:0] cmd,
                                            input logic signed [IO_WORD_W-1:0] value,
                                            input logic [POSITION_W-1:0] pos);
        t_result r;
        r.data   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (ring_fill == DEPTH) begin
                    r.status = ST_FULL;
                    n_full_push++;
                end else begin
                    ring_front = ring_front - 1'b1;
                    ring_words[ring_front] = value;
                    ring_fill++;
                end
            end
            CMD_PUSH_BACK: begin
                if (ring_fill == DEPTH) begin
                    r.status = ST_FULL;
                    n_full_push++;
                end else begin
                    ring_words[POSITION_W'(ring_front + ring_fill)] = value;
                    ring_fill++;
                end
            end
            CMD_POP_FRONT: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                    r.data   = -1;
                    n_empty_pop++;
                end else begin
                    r.data = ring_words[ring_front];
                    ring_front = ring_front + 1'b1;
                    ring_fill--;
                    n_good_pop++;
                end
            end
            CMD_POP_BACK: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                    r.data   = -1;
                    n_empty_pop++;
                end else begin
                    r.data = ring_words[POSITION_W'(ring_front + ring_fill - 1)];
                    ring_fill--;
                    n_good_pop++;
                end
            end
            CMD_READ: begin
                if ({1'b0, pos} >= ring_fill) begin
                    r.status = ST_RANGE;
                    r.data   = -1;
                    n_range_read++;
                end else begin
                    r.data = ring_words[POSITION_W'(ring_front + pos)];
                    n_good_read++;
                end
            end
            default: ;
        endcase
        r.count    = ring_fill;
        r.is_empty = (ring_fill == 0);
        if (ring_fill == 0) begin
            r.front_word = '0;
            r.back_word  = '0;
        end else begin
            r.front_word = ring_words[ring_front];
            r.back_word  = ring_words[POSITION_W'(ring_front + ring_fill - 1)];
        end
        return r;
    endfunction

    // Mostly random words, with the extremes, zero and the all-ones pattern mixed in.
    function automatic logic signed [IO_WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Hold the request until the block takes it, then record its expected result.
    task automatic send_request(input logic [2:0] cmd,
                                input logic signed [IO_WORD_W-1:0] value,
                                input logic [POSITION_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.insert(expected_results.size(), deque_apply(cmd, value, pos));
        n_sent++;
    endtask

    // One random request; push_pct steers the queue toward full or toward empty.
    task automatic send_random(input int push_pct);
        int roll;
        logic [2:0] cmd;
        logic [POSITION_W-1:0] pos;
        roll = $urandom_range(99);
        pos  = POSITION_W'($urandom_range(DEPTH - 1));
        if (roll < 2) begin
            cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end else if (roll < 2 + push_pct) begin
            cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else if (roll < 80) begin
            cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end else begin
            cmd = CMD_READ;
            // keep most reads inside the occupied span
            if (ring_fill != 0 && $urandom_range(99) < 80)
                pos = POSITION_W'($urandom_range(int'(ring_fill) - 1));
        end
        send_request(cmd, pick_word(), pos);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                     $time, name, want, want, got, got);
            err_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with nothing outstanding, data %0d status %0d",
                     $time, o_data, o_status);
            err_count++;
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            check_field("data",       want.data,       o_data);
            check_field("status",     want.status,     o_status);
            check_field("count",      want.count,      o_count);
            check_field("is_empty",   want.is_empty,   o_is_empty);
            check_field("front_word", want.front_word, o_front_word);
            check_field("back_word",  want.back_word,  o_back_word);
            n_checked++;
        end
    endtask

    // Result side: check each accepted result, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result();
        if (rx_holding)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver stall, counted here so the sender keeps offering requests.
    always begin
        @(rx_hold_go);
        rx_holding <= 1'b1;
        repeat (RX_HOLD_LEN) @(posedge i_clk);
        rx_holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Empty pops, empty read, unused commands, extreme words, reads in and out of range.
    task automatic test_directed_edges();
        int c;
        send_request(CMD_POP_FRONT, pick_word(), '0);
        send_request(CMD_POP_BACK, pick_word(), '1);
        send_request(CMD_READ, pick_word(), '0);
        for (c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_request(3'(c), $urandom, POSITION_W'($urandom_range(DEPTH - 1)));
        send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff, '0);
        send_request(CMD_PUSH_BACK, 32'sh8000_0000, '1);
        send_request(CMD_PUSH_FRONT, '0, '0);
        send_request(CMD_READ, '0, 4'd0);
        send_request(CMD_READ, '0, 4'd1);
        send_request(CMD_READ, '0, 4'd2);
        send_request(CMD_READ, '1, 4'd3);
        send_request(CMD_READ, '1, 4'd15);
        send_request(CMD_POP_BACK, '0, '0);
        send_request(CMD_POP_FRONT, '0, '0);
        send_request(CMD_POP_FRONT, '0, '0);
        send_request(CMD_POP_FRONT, '0, '0);
    endtask

    // Fill from both ends so the front index wraps, push into a full queue at both ends, then read the last slot.
    task automatic test_fill_to_capacity();
        int k;
        for (k = 0; k < DEPTH; k++)
            send_request(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word(), '0);
        send_request(CMD_PUSH_FRONT, pick_word(), '0);
        send_request(CMD_PUSH_BACK, pick_word(), '0);
        send_request(CMD_READ, '0, 4'd15);
    endtask

    // Stall the result side for a long stretch while requests keep coming.
    task automatic test_receiver_backpressure();
        int k;
        tx_idle_pct = 0;
        -> rx_hold_go;
        for (k = 0; k < 30; k++)
            send_random(40);
        tx_idle_pct = 25;
    endtask

    // Stop offering requests until every result is back, then resume.
    task automatic test_pause_until_drained();
        int k;
        for (k = 0; k < 20; k++)
            send_random(50);
        wait_for_drain();
        for (k = 0; k < 20; k++)
            send_random(40);
    endtask

    // No idling on either side: one request per cycle where the block allows it.
    task automatic test_back_to_back();
        int k;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (k = 0; k < 200; k++)
            send_random((k / 40) % 2 ? 20 : 60);
        tx_idle_pct = 25;
        rx_idle_pct = 25;
    endtask

    // Phases that grow, shrink or hover, so full, empty and wrap cases recur.
    task automatic test_random_mix(input int n_items);
        int k;
        int bias;
        bias = 40;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       bias = 60;
                    1:       bias = 20;
                    default: bias = 40;
                endcase
            end
            send_random(bias);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_fill_to_capacity();
        test_receiver_backpressure();
        test_pause_until_drained();
        test_back_to_back();
        test_random_mix(740);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d errors",
                 n_sent, n_checked, err_count);
        $display("pops %0d, empty pops %0d, full pushes %0d, reads %0d, out-of-range reads %0d",
                 n_good_pop, n_empty_pop, n_full_push, n_good_read, n_range_read);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
